// ===== rtl/core/okvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_GET    = 3'd1,
        OP_DEL    = 3'd2,
        OP_MIN    = 3'd3,
        OP_MAX    = 3'd4,
        OP_RSTART = 3'd5,
        OP_RNEXT  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_CMP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_UPDATE = 3'd3,
        CMD_DELETE = 3'd4
    } t_cell_cmd;

    typedef enum logic {
        SEL_HIT  = 1'b0,
        SEL_LAST = 1'b1
    } t_sel;

    typedef struct packed {
        t_cell_cmd cmd;
        t_sel      sel;
    } t_cell_ctl;

    typedef struct packed {
        logic lt;
        logic hit;
        logic eq;
        logic sel_a;
        logic sel_b;
    } t_cell_flags;

    typedef struct packed {
        logic found;
        logic a_any;
        logic b_any;
    } t_chain_stat;

    localparam t_cell_flags C_EDGE_FLAGS = '{lt: 1'b1, hit: 1'b0, eq: 1'b0,
                                             sel_a: 1'b0, sel_b: 1'b0};

endpackage

`default_nettype wire

// ===== rtl/core/okvt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module okvt_cell import okvt_pkg::*; #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int CW         = 7,
    parameter int IDX        = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [CW-1:0]         i_count,
    input  wire logic [KEY_BITS-1:0]   i_cmp_key,
    input  wire logic [KEY_BITS-1:0]   i_new_key,
    input  wire logic [VALUE_BITS-1:0] i_new_val,
    input  wire t_cell_flags           i_left_flags,
    input  wire logic [KEY_BITS-1:0]   i_left_key,
    input  wire logic [VALUE_BITS-1:0] i_left_val,
    input  wire logic [KEY_BITS-1:0]   i_right_key,
    input  wire logic [VALUE_BITS-1:0] i_right_val,
    output t_cell_flags                o_flags,
    output logic [KEY_BITS-1:0]        o_key,
    output logic [VALUE_BITS-1:0]      o_val
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_lt;
    logic                  r_eq;
    logic                  w_valid;
    logic                  w_last;
    logic                  w_hit;

    assign w_valid = (CW'(IDX) < i_count);
    assign w_last  = (CW'(IDX + 1) == i_count);
    assign w_hit   = w_valid && !r_lt && i_left_flags.lt;

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_CMP: begin
                r_lt <= w_valid && (r_key < i_cmp_key);
                r_eq <= w_valid && (r_key == i_cmp_key);
            end
            CMD_INSERT: begin
                if (!r_lt) begin
                    if (i_left_flags.lt) begin
                        r_key <= i_new_key;
                        r_val <= i_new_val;
                    end else begin
                        r_key <= i_left_key;
                        r_val <= i_left_val;
                    end
                end
            end
            CMD_UPDATE: begin
                if (r_eq) begin
                    r_val <= i_new_val;
                end
            end
            CMD_DELETE: begin
                if (!r_lt) begin
                    r_key <= i_right_key;
                    r_val <= i_right_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_flags.lt    = r_lt;
    assign o_flags.hit   = w_hit;
    assign o_flags.eq    = r_eq;
    assign o_flags.sel_a = (i_ctl.sel == SEL_LAST) ? w_last : w_hit;
    assign o_flags.sel_b = w_valid && i_left_flags.hit;
    assign o_key         = r_key;
    assign o_val         = r_val;

endmodule

`default_nettype wire

// ===== rtl/core/okvt_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module okvt_chain import okvt_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int CW         = 7
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [CW-1:0]         i_count,
    input  wire logic [KEY_BITS-1:0]   i_cmp_key,
    input  wire logic [KEY_BITS-1:0]   i_new_key,
    input  wire logic [VALUE_BITS-1:0] i_new_val,
    output t_chain_stat                o_stat,
    output logic [KEY_BITS-1:0]        o_a_key,
    output logic [VALUE_BITS-1:0]      o_a_val,
    output logic [KEY_BITS-1:0]        o_b_key
);

    t_cell_flags           w_flags [CAPACITY];
    logic [KEY_BITS-1:0]   w_key   [CAPACITY];
    logic [VALUE_BITS-1:0] w_val   [CAPACITY];
    t_cell_flags           w_lf    [CAPACITY];
    logic [KEY_BITS-1:0]   w_lk    [CAPACITY];
    logic [VALUE_BITS-1:0] w_lv    [CAPACITY];
    logic [KEY_BITS-1:0]   w_rk    [CAPACITY];
    logic [VALUE_BITS-1:0] w_rv    [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_left_edge
            assign w_lf[g] = C_EDGE_FLAGS;
            assign w_lk[g] = '0;
            assign w_lv[g] = '0;
        end else begin : g_left
            assign w_lf[g] = w_flags[g-1];
            assign w_lk[g] = w_key[g-1];
            assign w_lv[g] = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_right_edge
            assign w_rk[g] = '0;
            assign w_rv[g] = '0;
        end else begin : g_right
            assign w_rk[g] = w_key[g+1];
            assign w_rv[g] = w_val[g+1];
        end

        okvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .CW         (CW),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_count      (i_count),
            .i_cmp_key    (i_cmp_key),
            .i_new_key    (i_new_key),
            .i_new_val    (i_new_val),
            .i_left_flags (w_lf[g]),
            .i_left_key   (w_lk[g]),
            .i_left_val   (w_lv[g]),
            .i_right_key  (w_rk[g]),
            .i_right_val  (w_rv[g]),
            .o_flags      (w_flags[g]),
            .o_key        (w_key[g]),
            .o_val        (w_val[g])
        );
    end

    // selects are one-hot, so an and-or picks the entry
    always_comb begin
        o_stat  = '0;
        o_a_key = '0;
        o_a_val = '0;
        o_b_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            o_stat.found = o_stat.found | w_flags[i].eq;
            o_stat.a_any = o_stat.a_any | w_flags[i].sel_a;
            o_stat.b_any = o_stat.b_any | w_flags[i].sel_b;
            o_a_key = o_a_key | (w_key[i] & {KEY_BITS{w_flags[i].sel_a}});
            o_a_val = o_a_val | (w_val[i] & {VALUE_BITS{w_flags[i].sel_a}});
            o_b_key = o_b_key | (w_key[i] & {KEY_BITS{w_flags[i].sel_b}});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ordered_key_value_table.sv =====
// A transaction runs a compare cycle in the cell chain, then an update cycle, then
// the registered result strobe.
// Busy is high during the compare cycle of the cell chain, and the update cycle
// overlaps the next accept.
// Reset (synchronous, active low) clears the entry count and iterator; cell contents
// are not cleared. Results are strobed once and the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_value_table import okvt_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    i_op,
    input  wire logic [KEY_BITS-1:0]           i_key,
    input  wire logic [VALUE_BITS-1:0]         i_value,
    input  wire logic [KEY_BITS-1:0]           i_end_key,
    input  wire logic                          i_from_first,
    input  wire logic                          i_has_end,
    input  wire logic                          i_inclusive,
    output logic                               o_strobe,
    output logic [1:0]                         o_status,
    output logic [KEY_BITS-1:0]                o_key_out,
    output logic [VALUE_BITS-1:0]              o_found_value,
    output logic                               o_more,
    output logic [$clog2(CAPACITY+1)-1:0]      o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CMP   = 2'd1,
        S_APPLY = 2'd2
    } t_state;

    t_state                r_state, n_state;
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [KEY_BITS-1:0]   r_end;
    logic                  r_from_first;
    logic                  r_has_end;
    logic                  r_incl;

    logic [CW-1:0]         r_count, n_count;
    logic [KEY_BITS-1:0]   r_iter_next, n_iter_next;
    logic [KEY_BITS-1:0]   r_iter_bound, n_iter_bound;
    logic                  r_iter_active, n_iter_active;
    logic                  r_iter_bounded, n_iter_bounded;
    logic                  r_iter_incl, n_iter_incl;
    logic                  r_more, n_more;
    logic [KEY_BITS-1:0]   r_target, n_target;

    logic                  r_strobe, n_strobe;
    t_status               r_status, n_status;
    logic [KEY_BITS-1:0]   r_kout, n_kout;
    logic [VALUE_BITS-1:0] r_vout, n_vout;

    logic                  w_accept;
    t_cell_ctl             w_ctl;
    logic [KEY_BITS-1:0]   w_cmp_key;
    t_chain_stat           w_stat;
    logic [KEY_BITS-1:0]   w_a_key;
    logic [VALUE_BITS-1:0] w_a_val;
    logic [KEY_BITS-1:0]   w_b_key;

    function automatic logic within_bound(input logic [KEY_BITS-1:0] k,
                                          input logic [KEY_BITS-1:0] b,
                                          input logic bounded,
                                          input logic incl);
        return !bounded || (k < b) || (incl && (k == b));
    endfunction

    assign busy     = (r_state == S_CMP);
    assign w_accept = start && !busy;

    always_comb begin
        if (r_op == OP_RNEXT) begin
            w_cmp_key = r_iter_next;
        end else if ((r_op == OP_MIN) || ((r_op == OP_RSTART) && r_from_first)) begin
            w_cmp_key = '0;
        end else begin
            w_cmp_key = r_key;
        end
    end

    okvt_chain #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .CW         (CW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_count   (r_count),
        .i_cmp_key (w_cmp_key),
        .i_new_key (r_key),
        .i_new_val (r_val),
        .o_stat    (w_stat),
        .o_a_key   (w_a_key),
        .o_a_val   (w_a_val),
        .o_b_key   (w_b_key)
    );

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_iter_next    = r_iter_next;
        n_iter_bound   = r_iter_bound;
        n_iter_active  = r_iter_active;
        n_iter_bounded = r_iter_bounded;
        n_iter_incl    = r_iter_incl;
        n_more         = r_more;
        n_target       = r_target;
        n_strobe       = 1'b0;
        n_status       = r_status;
        n_kout         = r_kout;
        n_vout         = r_vout;
        w_ctl.cmd      = CMD_HOLD;
        w_ctl.sel      = (r_op == OP_MAX) ? SEL_LAST : SEL_HIT;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctl.cmd = CMD_CMP;
                n_state   = S_APPLY;
            end
            S_APPLY: begin
                n_state  = w_accept ? S_CMP : S_IDLE;
                n_strobe = 1'b1;
                n_status = ST_MISS;
                n_kout   = '0;
                n_vout   = '0;
                case (r_op)
                    OP_PUT: begin
                        if (w_stat.found) begin
                            w_ctl.cmd = CMD_UPDATE;
                            n_status  = ST_OK;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_ctl.cmd = CMD_INSERT;
                            n_count   = r_count + CW'(1);
                            n_status  = ST_OK;
                            if (r_iter_active && (r_key >= r_iter_next) &&
                                within_bound(r_key, r_iter_bound, r_iter_bounded,
                                             r_iter_incl) &&
                                (!r_more || (r_key < r_target))) begin
                                n_more   = 1'b1;
                                n_target = r_key;
                            end
                        end
                    end
                    OP_GET: begin
                        if (w_stat.found) begin
                            n_status = ST_OK;
                            n_vout   = w_a_val;
                        end
                    end
                    OP_DEL: begin
                        if (w_stat.found) begin
                            w_ctl.cmd = CMD_DELETE;
                            n_count   = r_count - CW'(1);
                            n_status  = ST_OK;
                            if (r_more && (r_key == r_target)) begin
                                n_target = w_b_key;
                                n_more   = w_stat.b_any &&
                                           within_bound(w_b_key, r_iter_bound,
                                                        r_iter_bounded, r_iter_incl);
                            end
                        end
                    end
                    OP_MIN, OP_MAX: begin
                        if (w_stat.a_any) begin
                            n_status = ST_OK;
                            n_kout   = w_a_key;
                            n_vout   = w_a_val;
                        end
                    end
                    OP_RSTART: begin
                        n_iter_bounded = r_has_end;
                        n_iter_bound   = r_end;
                        n_iter_incl    = r_incl;
                        if (w_stat.a_any && within_bound(w_a_key, r_end, r_has_end, r_incl))
                        begin
                            n_status      = ST_OK;
                            n_iter_next   = w_a_key;
                            n_iter_active = 1'b1;
                            n_more        = 1'b1;
                            n_target      = w_a_key;
                        end else begin
                            n_iter_active = 1'b0;
                            n_more        = 1'b0;
                        end
                    end
                    OP_RNEXT: begin
                        if (!r_more) begin
                            n_iter_active = 1'b0;
                        end else begin
                            n_status = ST_OK;
                            n_kout   = w_a_key;
                            n_vout   = w_a_val;
                            if (w_stat.b_any && within_bound(w_b_key, r_iter_bound,
                                                             r_iter_bounded, r_iter_incl))
                            begin
                                n_iter_next = w_b_key;
                                n_target    = w_b_key;
                            end else begin
                                n_iter_active = 1'b0;
                                n_more        = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_iter_next    <= '0;
            r_iter_bound   <= '0;
            r_iter_active  <= 1'b0;
            r_iter_bounded <= 1'b0;
            r_iter_incl    <= 1'b0;
            r_more         <= 1'b0;
            r_target       <= '0;
            r_strobe       <= 1'b0;
            r_status       <= ST_OK;
            r_kout         <= '0;
            r_vout         <= '0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_iter_next    <= n_iter_next;
            r_iter_bound   <= n_iter_bound;
            r_iter_active  <= n_iter_active;
            r_iter_bounded <= n_iter_bounded;
            r_iter_incl    <= n_iter_incl;
            r_more         <= n_more;
            r_target       <= n_target;
            r_strobe       <= n_strobe;
            r_status       <= n_status;
            r_kout         <= n_kout;
            r_vout         <= n_vout;
        end
        if (w_accept) begin
            r_op         <= t_op'(i_op);
            r_key        <= i_key;
            r_val        <= i_value;
            r_end        <= i_end_key;
            r_from_first <= i_from_first;
            r_has_end    <= i_has_end;
            r_incl       <= i_inclusive;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_key_out     = r_kout;
    assign o_found_value = r_vout;
    assign o_more        = r_more;
    assign o_entry_count = r_count;

    a_cmp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("compare phase lasted more than one cycle");

    a_apply_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> ($past(r_state) == S_CMP))
        else $error("update phase entered without a compare phase");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_APPLY))
        else $error("result strobe without an update phase");

    a_more_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_more |-> r_iter_active)
        else $error("iterator reports more while inactive");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_FULL)) |-> (o_entry_count == CW'(CAPACITY)))
        else $error("full status with free entries");

endmodule

`default_nettype wire
